>>> src/esu8_pkg.sv
package esu8_pkg;

  // Depth of the queue between the parser and the UTF-8 serialiser.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // How the byte that follows a flushed code point is written out.
  localparam logic [1:0] PLAIN_NONE   = 2'd0;
  localparam logic [1:0] PLAIN_SINGLE = 2'd1;
  localparam logic [1:0] PLAIN_LATIN1 = 2'd2;

  // One request from the parser to the serialiser: an optional code point
  // of one to six bytes, then an optional plain byte of one or two bytes.
  typedef struct packed {
    logic [31:0] code;
    logic [2:0]  flush_len;
    logic [1:0]  plain_kind;
    logic [7:0]  plain_byte;
    logic        last;
  } job_t;

endpackage

>>> src/esu8_front.sv
module esu8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                end_of_value_i,
  output logic                push_o,
  output esu8_pkg::job_t      job_o
);
  import esu8_pkg::*;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_OCT   = 2'd2;
  localparam logic [1:0] MODE_HEX   = 2'd3;

  logic        latin1_q;
  logic [1:0]  mode_q, mode_d;
  logic [31:0] cp_q, cp_d;
  logic        ovf_q, ovf_d;
  logic [3:0]  left_q, left_d;

  logic        do_flush;
  logic [31:0] flush_cp;
  logic        flush_ovf;
  logic [1:0]  pkind;
  logic [7:0]  pbyte;
  logic [2:0]  flen;
  logic        is_oct;
  logic        hex_ok;
  logic [3:0]  hex_val;

  // Hex digit decode of the incoming byte.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h41 && in_byte_i <= 8'h46) ||
                 (in_byte_i >= 8'h61 && in_byte_i <= 8'h66)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_oct = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h37);

  // Parser: next state and the request that this byte causes.
  always_comb begin
    mode_d    = mode_q;
    cp_d      = cp_q;
    ovf_d     = ovf_q;
    left_d    = left_q;
    do_flush  = 1'b0;
    flush_cp  = cp_q;
    flush_ovf = ovf_q;
    pkind     = PLAIN_NONE;
    pbyte     = in_byte_i;

    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        unique case (in_byte_i) inside
          8'h6E: begin pkind = PLAIN_SINGLE; pbyte = 8'h0A; end
          8'h72: begin pkind = PLAIN_SINGLE; pbyte = 8'h0D; end
          8'h74: begin pkind = PLAIN_SINGLE; pbyte = 8'h09; end
          8'h66: begin pkind = PLAIN_SINGLE; pbyte = 8'h0C; end
          8'h76: begin pkind = PLAIN_SINGLE; pbyte = 8'h0B; end
          [8'h30:8'h37]: begin
            cp_d   = {29'd0, in_byte_i[2:0]};
            ovf_d  = 1'b0;
            mode_d = MODE_OCT;
          end
          8'h78, 8'h58, 8'h75, 8'h55: begin
            cp_d   = 32'd0;
            ovf_d  = 1'b0;
            left_d = (in_byte_i == 8'h75) ? 4'd4 :
                     (in_byte_i == 8'h55) ? 4'd8 : 4'd2;
            mode_d = MODE_HEX;
          end
          default: pkind = PLAIN_SINGLE;
        endcase
      end
      MODE_OCT: begin
        if (is_oct) begin
          if (cp_q[31:29] != 3'd0) begin
            ovf_d = 1'b1;
          end
          cp_d = {cp_q[28:0], in_byte_i[2:0]};
        end else begin
          do_flush = 1'b1;
          mode_d   = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          cp_d   = {cp_q[27:0], hex_val};
          left_d = left_q - 4'd1;
          if (left_d == 4'd0) begin
            do_flush = 1'b1;
            flush_cp = cp_d;
            mode_d   = MODE_PLAIN;
          end
        end else begin
          do_flush = 1'b1;
          mode_d   = MODE_PLAIN;
        end
      end
      default: ;
    endcase

    // A plain byte: from plain mode, or the byte that ended a run.
    if (mode_q == MODE_PLAIN || (do_flush && !(mode_q == MODE_HEX && hex_ok))) begin
      if (in_byte_i == 8'h5C) begin
        if (!end_of_value_i) begin
          mode_d = MODE_ESC;
        end
      end else if (latin1_q && in_byte_i[7]) begin
        pkind = PLAIN_LATIN1;
      end else begin
        pkind = PLAIN_SINGLE;
      end
    end

    // The end of the value flushes an open run.
    if (end_of_value_i && (mode_d == MODE_OCT || mode_d == MODE_HEX)) begin
      do_flush  = 1'b1;
      flush_cp  = cp_d;
      flush_ovf = ovf_d;
    end

    // A flush or end of value returns the parser to plain text, unless a flushing backslash opens an escape.
    if (do_flush || end_of_value_i) begin
      cp_d   = 32'd0;
      ovf_d  = 1'b0;
      left_d = 4'd0;
      if (do_flush || end_of_value_i) begin
        if (end_of_value_i || mode_d != MODE_ESC) begin
          mode_d = MODE_PLAIN;
        end
      end
    end
  end

  // Length of the UTF-8 form of the flushed code point.
  always_comb begin
    if (!do_flush) begin
      flen = 3'd0;
    end else if (flush_ovf) begin
      flen = 3'd6;
    end else if (flush_cp[31:7] == 25'd0) begin
      flen = 3'd1;
    end else if (flush_cp[31:11] == 21'd0) begin
      flen = 3'd2;
    end else if (flush_cp[31:16] == 16'd0) begin
      flen = 3'd3;
    end else if (flush_cp[31:21] == 11'd0) begin
      flen = 3'd4;
    end else if (flush_cp[31:26] == 6'd0) begin
      flen = 3'd5;
    end else begin
      flen = 3'd6;
    end
  end

  assign job_o.code       = flush_cp;
  assign job_o.flush_len  = flen;
  assign job_o.plain_kind = pkind;
  assign job_o.plain_byte = pbyte;
  assign job_o.last       = end_of_value_i;

  // Only requests that produce at least one result go into the queue.
  assign push_o = accept_i && (do_flush || pkind != PLAIN_NONE || end_of_value_i);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latin1_q <= 1'b0;
    end else if (cfg_we_i) begin
      latin1_q <= cfg_wdata_i;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      cp_q   <= 32'd0;
      ovf_q  <= 1'b0;
      left_q <= 4'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
      ovf_q  <= ovf_d;
      left_q <= left_d;
    end
  end

endmodule

>>> src/esu8_fifo.sv
module esu8_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  esu8_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output esu8_pkg::job_t head_job_o
);
  import esu8_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rptr_q];

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

>>> src/esu8_back.sv
module esu8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  esu8_pkg::job_t head_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           byte_valid_o,
  output logic           last_of_value_o
);
  import esu8_pkg::*;

  logic [2:0] step_q, step_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       byte_valid_q;
  logic       last_q;

  logic       adv;
  logic       emit;
  logic       is_final;
  logic [3:0] total;
  logic [2:0] len;
  logic [2:0] sh;
  logic [2:0] pstep;
  logic [5:0] grp;
  logic [7:0] cur_byte;

  assign len = head_job_i.flush_len;

  // Number of bytes in the request at the head of the queue.
  always_comb begin
    case (head_job_i.plain_kind)
      PLAIN_SINGLE: total = {1'b0, len} + 4'd1;
      PLAIN_LATIN1: total = {1'b0, len} + 4'd2;
      default:      total = {1'b0, len};
    endcase
  end

  // Six-bit group of the code point for a continuation byte.
  assign sh    = len - 3'd1 - step_q;
  assign pstep = step_q - len;
  always_comb begin
    case (sh)
      3'd0:    grp = head_job_i.code[5:0];
      3'd1:    grp = head_job_i.code[11:6];
      3'd2:    grp = head_job_i.code[17:12];
      3'd3:    grp = head_job_i.code[23:18];
      3'd4:    grp = head_job_i.code[29:24];
      default: grp = 6'd0;
    endcase
  end

  // Byte for the current step: lead byte, continuation or plain byte.
  always_comb begin
    cur_byte = 8'd0;
    if (step_q < len) begin
      if (step_q == 3'd0) begin
        case (len)
          3'd1:    cur_byte = head_job_i.code[7:0];
          3'd2:    cur_byte = {3'b110, head_job_i.code[10:6]};
          3'd3:    cur_byte = {4'b1110, head_job_i.code[15:12]};
          3'd4:    cur_byte = {5'b11110, head_job_i.code[20:18]};
          3'd5:    cur_byte = {6'b111110, head_job_i.code[25:24]};
          default: cur_byte = {6'b111111, head_job_i.code[31:30]};
        endcase
      end else begin
        cur_byte = {2'b10, grp};
      end
    end else if (pstep == 3'd0) begin
      if (head_job_i.plain_kind == PLAIN_LATIN1) begin
        cur_byte = {6'b110000, head_job_i.plain_byte[7:6]};
      end else begin
        cur_byte = head_job_i.plain_byte;
      end
    end else begin
      cur_byte = {2'b10, head_job_i.plain_byte[5:0]};
    end
  end

  // Step through the request; release it with its last byte.
  assign adv      = !out_valid_q || out_ready_i;
  assign emit     = head_valid_i && adv;
  assign is_final = (total == 4'd0) || ({1'b0, step_q} == total - 4'd1);
  assign pop_o    = emit && is_final;

  always_comb begin
    step_d = step_q;
    if (emit) begin
      step_d = is_final ? 3'd0 : step_q + 3'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (adv) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= (total == 4'd0) ? 8'd0 : cur_byte;
      byte_valid_q <= (total != 4'd0);
      last_q       <= is_final && head_job_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = byte_valid_q;
  assign last_of_value_o = last_q;

endmodule

>>> src/escape_sequence_to_utf8_decoder.sv
// Backslash-escape decoder with UTF-8 output. Bytes of a value string go in
// one per request; decoded UTF-8 bytes come out one per request. A parser
// accepts one input byte per cycle whenever its two-entry queue has room;
// the serialiser behind the queue sends one output byte per cycle unless
// out_ready_i stalls it. An input byte yields at most eight output bytes (a
// code point of up to six bytes and a plain byte of up to two); input bytes
// that yield nothing are not queued unless they end the value. Results go
// through the queue and the output register. The user must write latin1_mode
// via cfg_we_i/cfg_wdata_i while the block is idle; it does not enforce this.
module escape_sequence_to_utf8_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       last_of_value_o
);
  import esu8_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  // Input request is taken whenever the queue can hold its result.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  esu8_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_value_i (end_of_value_i),
    .push_o         (push),
    .job_o          (push_job)
  );

  esu8_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  esu8_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_job_i      (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_of_value_o (last_of_value_o)
  );

endmodule
